// ===== rtl/sdinit_pkg.sv =====
package sdinit_pkg;

	localparam int unsigned RESPONSE_LENGTH = 5;
	localparam int unsigned FRAME_LENGTH = 6;

	localparam logic [7:0] WAKE_COUNT_RESET = 8'd10;
	localparam logic [15:0] POLL_LIMIT_RESET = 16'hFFFF;
	localparam logic [7:0] RETRY_LIMIT_RESET = 8'hFF;

	localparam logic [7:0] CMD_START = 8'h40;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] CRC_CMD8 = 8'h87;
	localparam logic [7:0] CRC_OTHER = 8'h01;
	localparam logic [31:0] ARG_CMD8 = 32'h0000_01AA;
	localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
	localparam logic [7:0] R1_IDLE = 8'h01;
	localparam logic [7:0] R1_READY = 8'h00;
	localparam logic [7:0] R1_ERROR_MASK = 8'hFE;
	localparam logic [7:0] CHECK_PATTERN = 8'hAA;
	localparam logic [7:0] VOLTAGE_MASK = 8'h20;
	localparam logic [7:0] CCS_MASK = 8'hC0;
	localparam logic [7:0] IDLE_BYTE = 8'hFF;

	localparam logic [7:0] CMD_GO_IDLE = 8'd0;
	localparam logic [7:0] CMD_SEND_IF_COND = 8'd8;
	localparam logic [7:0] CMD_READ_OCR = 8'd58;
	localparam logic [7:0] CMD_APP = 8'd55;
	localparam logic [7:0] CMD_OP_COND = 8'd41;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_COMM = 3'd1;
	localparam logic [2:0] ST_RESPONSE = 3'd2;
	localparam logic [2:0] ST_VOLTAGE = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;

	localparam logic [1:0] CFG_WAKE_COUNT = 2'd0;
	localparam logic [1:0] CFG_POLL_LIMIT = 2'd1;
	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAKE,
		PH_SEND,
		PH_POLL,
		PH_DATA,
		PH_TRAIL,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		STEP_CMD0,
		STEP_CMD8,
		STEP_OCR1,
		STEP_APP,
		STEP_OPCOND,
		STEP_OCR2
	} step_t;

	typedef struct packed {
		phase_t phase;
		step_t step;
		logic [2:0] frame_idx;
		logic [15:0] poll_cnt;
		logic [7:0] retry_cnt;
		logic capacity;
		logic [2:0] status;
	} seq_state_t;

	typedef struct packed {
		logic [7:0] wake_count;
		logic [15:0] poll_limit;
		logic [7:0] retry_limit;
	} seq_cfg_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] received_byte;
		logic link_fault;
	} seq_item_t;

	typedef struct packed {
		logic [7:0] transmit_byte;
		logic exchange_wanted;
		logic card_select_level;
		logic finished;
		logic [2:0] status_code;
		logic high_capacity_card;
	} seq_result_t;

	typedef struct packed {
		logic we;
		logic [2:0] addr;
		logic [7:0] data;
	} buf_write_t;

	function automatic logic [7:0] step_cmd(input step_t s);
		case (s)
			STEP_CMD0: step_cmd = CMD_GO_IDLE;
			STEP_CMD8: step_cmd = CMD_SEND_IF_COND;
			STEP_APP: step_cmd = CMD_APP;
			STEP_OPCOND: step_cmd = CMD_OP_COND;
			default: step_cmd = CMD_READ_OCR;
		endcase
	endfunction

	function automatic logic [31:0] step_arg(input step_t s);
		case (s)
			STEP_CMD8: step_arg = ARG_CMD8;
			STEP_OPCOND: step_arg = ARG_ACMD41;
			default: step_arg = 32'd0;
		endcase
	endfunction

	function automatic logic [7:0] frame_byte(input step_t s, input logic [2:0] idx);
		logic [7:0] c;
		logic [31:0] a;
		c = step_cmd(s);
		a = step_arg(s);
		case (idx)
			3'd0: frame_byte = CMD_START | c;
			3'd1: frame_byte = a[31:24];
			3'd2: frame_byte = a[23:16];
			3'd3: frame_byte = a[15:8];
			3'd4: frame_byte = a[7:0];
			default: begin
				if (c == CMD_GO_IDLE)
					frame_byte = CRC_CMD0;
				else if (c == CMD_SEND_IF_COND)
					frame_byte = CRC_CMD8;
				else
					frame_byte = CRC_OTHER;
			end
		endcase
	endfunction

endpackage

// ===== rtl/sd_card_spi_init_sequencer.sv =====
// channel  handshake            payload
// in       in_valid/in_ready    req_type, received_byte, link_fault
// out      out_valid/out_ready  transmit_byte, exchange_wanted, card_select_level,
//                               finished, status_code, high_capacity_card
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// from input transaction to result: input register, then a
// combinational state update into the result register
// one transaction per cycle sustained while out_ready stays high
// a stalled result holds the result register; the input register still takes one more item
// reset clears phase and counters; configuration registers return to their defaults
module sd_card_spi_init_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic req_type,
	input logic [7:0] received_byte,
	input logic link_fault,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] transmit_byte,
	output logic exchange_wanted,
	output logic card_select_level,
	output logic finished,
	output logic [2:0] status_code,
	output logic high_capacity_card,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	sdinit_pkg::seq_cfg_t cfg_q;
	sdinit_pkg::seq_state_t st_q, st_nx;
	sdinit_pkg::seq_item_t item_s1;
	sdinit_pkg::buf_write_t bw;
	sdinit_pkg::seq_result_t res, res_s2;
	logic [sdinit_pkg::RESPONSE_LENGTH-1:0][7:0] rsp_q;
	logic valid_s1, valid_s2, advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_count <= sdinit_pkg::WAKE_COUNT_RESET;
			cfg_q.poll_limit <= sdinit_pkg::POLL_LIMIT_RESET;
			cfg_q.retry_limit <= sdinit_pkg::RETRY_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdinit_pkg::CFG_WAKE_COUNT: cfg_q.wake_count <= cfg_data[7:0];
				sdinit_pkg::CFG_POLL_LIMIT: cfg_q.poll_limit <= cfg_data;
				sdinit_pkg::CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.req_type <= req_type;
			item_s1.received_byte <= received_byte;
			item_s1.link_fault <= link_fault;
		end
	end

	sdinit_step u_step (
		.st(st_q),
		.cfg(cfg_q),
		.item(item_s1),
		.rsp(rsp_q),
		.nx(st_nx),
		.bw(bw),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= sdinit_pkg::PH_IDLE;
			st_q.step <= sdinit_pkg::STEP_CMD0;
			st_q.frame_idx <= 3'd0;
			st_q.poll_cnt <= 16'd0;
			st_q.retry_cnt <= 8'd0;
			st_q.capacity <= 1'b0;
			st_q.status <= sdinit_pkg::ST_OK;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && bw.we)
			rsp_q[bw.addr] <= bw.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign transmit_byte = res_s2.transmit_byte;
	assign exchange_wanted = res_s2.exchange_wanted;
	assign card_select_level = res_s2.card_select_level;
	assign finished = res_s2.finished;
	assign status_code = res_s2.status_code;
	assign high_capacity_card = res_s2.high_capacity_card;

endmodule

// ===== rtl/sdinit_step.sv =====
module sdinit_step (
	input sdinit_pkg::seq_state_t st,
	input sdinit_pkg::seq_cfg_t cfg,
	input sdinit_pkg::seq_item_t item,
	input logic [sdinit_pkg::RESPONSE_LENGTH-1:0][7:0] rsp,
	output sdinit_pkg::seq_state_t nx,
	output sdinit_pkg::buf_write_t bw,
	output sdinit_pkg::seq_result_t res
);

	logic [15:0] poll_inc;
	logic [2:0] idx_inc;
	logic [7:0] retry_inc;
	logic long_rsp;

	assign poll_inc = st.poll_cnt + 16'd1;
	assign idx_inc = st.frame_idx + 3'd1;
	assign retry_inc = st.retry_cnt + 8'd1;
	assign long_rsp = (st.step == sdinit_pkg::STEP_CMD8) || (st.step == sdinit_pkg::STEP_OCR1)
		|| (st.step == sdinit_pkg::STEP_OCR2);

	always_comb begin
		nx = st;
		bw.we = 1'b0;
		bw.addr = st.frame_idx;
		bw.data = item.received_byte;
		if (!item.req_type) begin
			nx.frame_idx = 3'd0;
			nx.poll_cnt = 16'd0;
			nx.retry_cnt = 8'd0;
			nx.capacity = 1'b0;
			nx.status = sdinit_pkg::ST_OK;
			nx.step = sdinit_pkg::STEP_CMD0;
			nx.phase = sdinit_pkg::PH_WAKE;
		end else if (st.phase != sdinit_pkg::PH_IDLE && st.phase != sdinit_pkg::PH_DONE) begin
			if (item.link_fault) begin
				nx.phase = sdinit_pkg::PH_DONE;
				nx.status = sdinit_pkg::ST_COMM;
			end else begin
				case (st.phase)
					sdinit_pkg::PH_WAKE: begin
						nx.poll_cnt = poll_inc;
						if (poll_inc >= {8'd0, cfg.wake_count}) begin
							nx.step = sdinit_pkg::STEP_CMD0;
							nx.frame_idx = 3'd0;
							nx.phase = sdinit_pkg::PH_SEND;
						end
					end
					sdinit_pkg::PH_SEND: begin
						nx.frame_idx = idx_inc;
						if (idx_inc >= 3'(sdinit_pkg::FRAME_LENGTH)) begin
							nx.phase = sdinit_pkg::PH_POLL;
							nx.poll_cnt = 16'd0;
						end
					end
					sdinit_pkg::PH_POLL: begin
						nx.poll_cnt = poll_inc;
						if (item.received_byte == sdinit_pkg::IDLE_BYTE) begin
							if (poll_inc >= cfg.poll_limit || poll_inc == 16'd0) begin
								nx.phase = sdinit_pkg::PH_DONE;
								nx.status = sdinit_pkg::ST_COMM;
							end
						end else begin
							bw.we = 1'b1;
							bw.addr = 3'd0;
							if ((item.received_byte & sdinit_pkg::R1_ERROR_MASK) != 8'd0) begin
								nx.phase = sdinit_pkg::PH_DONE;
								nx.status = (st.step == sdinit_pkg::STEP_APP
									|| st.step == sdinit_pkg::STEP_OPCOND)
									? sdinit_pkg::ST_RESPONSE : sdinit_pkg::ST_COMM;
							end else if (long_rsp) begin
								nx.frame_idx = 3'd1;
								nx.phase = sdinit_pkg::PH_DATA;
							end else begin
								nx.phase = sdinit_pkg::PH_TRAIL;
							end
						end
					end
					sdinit_pkg::PH_DATA: begin
						bw.we = (st.frame_idx < 3'(sdinit_pkg::RESPONSE_LENGTH));
						nx.frame_idx = idx_inc;
						if (idx_inc >= 3'(sdinit_pkg::RESPONSE_LENGTH))
							nx.phase = sdinit_pkg::PH_TRAIL;
					end
					sdinit_pkg::PH_TRAIL: begin
						nx.frame_idx = 3'd0;
						nx.phase = sdinit_pkg::PH_SEND;
						case (st.step)
							sdinit_pkg::STEP_CMD0: begin
								if (rsp[0] != sdinit_pkg::R1_IDLE) begin
									nx.phase = sdinit_pkg::PH_DONE;
									nx.status = sdinit_pkg::ST_RESPONSE;
								end else
									nx.step = sdinit_pkg::STEP_CMD8;
							end
							sdinit_pkg::STEP_CMD8: begin
								nx.phase = sdinit_pkg::PH_DONE;
								if (rsp[0] != sdinit_pkg::R1_IDLE)
									nx.status = sdinit_pkg::ST_RESPONSE;
								else if (rsp[3] != sdinit_pkg::R1_IDLE)
									nx.status = sdinit_pkg::ST_VOLTAGE;
								else if (rsp[4] != sdinit_pkg::CHECK_PATTERN)
									nx.status = sdinit_pkg::ST_CHECK;
								else begin
									nx.phase = sdinit_pkg::PH_SEND;
									nx.step = sdinit_pkg::STEP_OCR1;
								end
							end
							sdinit_pkg::STEP_OCR1: begin
								nx.phase = sdinit_pkg::PH_DONE;
								if (rsp[0] != sdinit_pkg::R1_IDLE)
									nx.status = sdinit_pkg::ST_RESPONSE;
								else if ((rsp[2] & sdinit_pkg::VOLTAGE_MASK) == 8'd0)
									nx.status = sdinit_pkg::ST_VOLTAGE;
								else begin
									nx.phase = sdinit_pkg::PH_SEND;
									nx.retry_cnt = 8'd0;
									nx.step = sdinit_pkg::STEP_APP;
								end
							end
							sdinit_pkg::STEP_APP: begin
								if (rsp[0] != sdinit_pkg::R1_IDLE) begin
									nx.phase = sdinit_pkg::PH_DONE;
									nx.status = sdinit_pkg::ST_RESPONSE;
								end else
									nx.step = sdinit_pkg::STEP_OPCOND;
							end
							sdinit_pkg::STEP_OPCOND: begin
								nx.retry_cnt = retry_inc;
								if (rsp[0] == sdinit_pkg::R1_READY)
									nx.step = sdinit_pkg::STEP_OCR2;
								else if (retry_inc >= cfg.retry_limit || retry_inc == 8'd0) begin
									nx.phase = sdinit_pkg::PH_DONE;
									nx.status = sdinit_pkg::ST_TIMEOUT;
								end else
									nx.step = sdinit_pkg::STEP_APP;
							end
							default: begin
								nx.phase = sdinit_pkg::PH_DONE;
								if (rsp[0] != sdinit_pkg::R1_READY)
									nx.status = sdinit_pkg::ST_RESPONSE;
								else begin
									nx.capacity = ((rsp[1] & sdinit_pkg::CCS_MASK)
										== sdinit_pkg::CCS_MASK);
									nx.status = sdinit_pkg::ST_OK;
								end
							end
						endcase
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		res.transmit_byte = 8'd0;
		res.exchange_wanted = 1'b0;
		res.card_select_level = 1'b1;
		res.finished = 1'b0;
		res.status_code = sdinit_pkg::ST_OK;
		res.high_capacity_card = nx.capacity;
		case (nx.phase)
			sdinit_pkg::PH_WAKE: begin
				res.transmit_byte = sdinit_pkg::IDLE_BYTE;
				res.exchange_wanted = 1'b1;
			end
			sdinit_pkg::PH_SEND: begin
				res.transmit_byte = sdinit_pkg::frame_byte(nx.step, nx.frame_idx);
				res.exchange_wanted = 1'b1;
				res.card_select_level = 1'b0;
			end
			sdinit_pkg::PH_POLL, sdinit_pkg::PH_DATA, sdinit_pkg::PH_TRAIL: begin
				res.transmit_byte = sdinit_pkg::IDLE_BYTE;
				res.exchange_wanted = 1'b1;
				res.card_select_level = 1'b0;
			end
			sdinit_pkg::PH_DONE: begin
				res.finished = 1'b1;
				res.status_code = nx.status;
			end
			default: ;
		endcase
	end

endmodule
